[hw/rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and word-level helpers for the block bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned WordW     = 32;
  localparam int unsigned OffW      = $clog2(WordW);
  localparam int unsigned NumWords  = MaxBlocks / WordW;
  localparam int unsigned WidxW     = $clog2(NumWords);
  localparam int unsigned BlkW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);
  localparam int unsigned PopW      = $clog2(WordW + 1);
  localparam int unsigned CmdW      = 3;
  localparam int unsigned StatW     = 2;

  localparam logic [CmdW-1:0] CmdOccupy   = 3'd0;
  localparam logic [CmdW-1:0] CmdFree     = 3'd1;
  localparam logic [CmdW-1:0] CmdFindFree = 3'd2;
  localparam logic [CmdW-1:0] CmdContig   = 3'd3;
  localparam logic [CmdW-1:0] CmdTest     = 3'd4;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatNoFree = 2'd1;
  localparam logic [StatW-1:0] StatRange  = 2'd2;

  typedef logic [WordW-1:0] word_t;

  // bits of word w whose block index is below lim
  function automatic word_t below_mask(input logic [WidxW-1:0] w,
                                       input logic [CntW-1:0] lim);
    logic [CntW-OffW-1:0] hi;
    logic [CntW-OffW-1:0] wx;
    word_t m;
    hi = lim[CntW-1:OffW];
    wx = (CntW-OffW)'(w);
    if (hi > wx) begin
      m = '1;
    end else if (hi == wx) begin
      m = (word_t'(1) << lim[OffW-1:0]) - word_t'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic [PopW-1:0] popcount(input word_t v);
    logic [PopW-1:0] c;
    c = '0;
    for (int i = 0; i < WordW; i++) begin
      c = c + PopW'(v[i]);
    end
    return c;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic logic [OffW-1:0] lsb_index(input word_t v);
    logic [OffW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = OffW'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// Used/free bitmap over storage blocks, kept in a 32 x 32 bit RAM and walked
// one word per cycle for run updates, scans and the free block count.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   cmd_i, start_block_i, run_length_i
//   out       output     out_valid_o / out_ready_i answer_o, free_total_o, status_o
//   cfg       input      cfg_we_i                  cfg_wdata_i (blocks in use)
//
// every command sweeps all 32 map words, reading word k through the registered
// RAM read port while word k-1 is modified and written back; the result is then
// loaded in the done state and the block returns to idle, the only state that takes a new transfer.
// reset clears a valid bit per word; an unwritten word reads as all free,
// so no clearing pass is needed. a new item is taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bba_pkg::CntW-1:0]       cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [bba_pkg::CmdW-1:0]       cmd_i,
  input  wire logic [bba_pkg::BlkW-1:0]       start_block_i,
  input  wire logic [bba_pkg::CntW-1:0]       run_length_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [bba_pkg::CntW-1:0]       answer_o,
  output logic      [bba_pkg::CntW-1:0]       free_total_o,
  output logic      [bba_pkg::StatW-1:0]      status_o
);

  import bba_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SDone = 2'd2;

  localparam int unsigned StepW = WidxW + 1;

  logic [1:0]          state_q, state_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [CntW-1:0]     blocks_q;
  logic [CntW-1:0]     n_act;
  logic [CmdW-1:0]     cmd_q;
  logic [BlkW-1:0]     start_q;
  logic [CntW-1:0]     len_q;
  logic [CntW-1:0]     ans_q, ans_d;
  logic [CntW-1:0]     free_q, free_d;
  logic                found_q, found_d;
  logic                run_q, run_d;
  logic [NumWords-1:0] vld_q;
  logic                vld_rd_q;
  logic                out_valid_q;
  logic [CntW-1:0]     answer_q;
  logic [CntW-1:0]     free_total_q;
  logic [StatW-1:0]    status_q;

  logic                in_xfer;
  logic                out_free;
  logic                rd_en;
  logic [WidxW-1:0]    rd_addr;
  logic                proc;
  logic [WidxW-1:0]    pw;
  logic                wr_en;
  word_t               rd_data;
  word_t               old_word;
  word_t               new_word;
  word_t               n_mask;
  word_t               s_mask;
  word_t               run_mask;
  word_t               free_bits;
  word_t               span;
  word_t               used;
  logic [CntW-1:0]     start_x;
  logic [CntW:0]       run_end;
  logic                is_run;
  logic                range_bad;
  logic [CntW-1:0]     fin_answer;
  logic [StatW-1:0]    fin_status;

  assign n_act   = (blocks_q > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : blocks_q;
  assign start_x = CntW'(start_q);
  assign run_end = (CntW+1)'(start_x) + (CntW+1)'(len_q);
  assign is_run  = (cmd_q == CmdOccupy) || (cmd_q == CmdFree);

  always_comb begin
    range_bad = 1'b0;
    if (is_run) begin
      range_bad = run_end > (CntW+1)'(n_act);
    end else if (cmd_q == CmdContig) begin
      range_bad = start_x > n_act;
    end else if (cmd_q == CmdTest) begin
      range_bad = start_x >= n_act;
    end
  end

  // sweep control: read word k while word k-1 is modified and written back
  assign in_ready_o = (state_q == SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_en      = (state_q == SScan) && !step_q[WidxW];
  assign rd_addr    = step_q[WidxW-1:0];
  assign proc       = (state_q == SScan) && (step_q != '0);
  assign pw         = WidxW'(step_q - StepW'(1));

  bba_ram #(
    .Width (WordW),
    .Depth (NumWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pw),
    .wdata_i (new_word),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    old_word  = vld_rd_q ? rd_data : '0;
    n_mask    = below_mask(pw, n_act);
    s_mask    = ~below_mask(pw, start_x);
    run_mask  = s_mask & below_mask(pw, run_end[CntW-1:0]);
    free_bits = ~old_word & n_mask;
    span      = s_mask & n_mask;
    used      = old_word & span;
    new_word  = old_word;
    if (!range_bad && (cmd_q == CmdOccupy)) begin
      new_word = old_word | run_mask;
    end else if (!range_bad && (cmd_q == CmdFree)) begin
      new_word = old_word & ~run_mask;
    end
    wr_en = proc && is_run && !range_bad;
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ans_d   = ans_q;
    free_d  = free_q;
    found_d = found_q;
    run_d   = run_q;
    unique case (state_q)
      SIdle: begin
        if (in_xfer) begin
          state_d = SScan;
          step_d  = '0;
          ans_d   = '0;
          free_d  = '0;
          found_d = 1'b0;
          run_d   = 1'b1;
        end
      end
      SScan: begin
        step_d = step_q + StepW'(1);
        if (step_q[WidxW]) begin
          state_d = SDone;
        end
        if (proc) begin
          free_d = free_q + CntW'(popcount(~new_word & n_mask));
          if (cmd_q == CmdFindFree) begin
            if (!found_q && (free_bits != '0)) begin
              found_d = 1'b1;
              ans_d   = CntW'({pw, lsb_index(free_bits)});
            end
          end else if (cmd_q == CmdContig) begin
            if (run_q) begin
              if (used == '0) begin
                ans_d = ans_q + CntW'(popcount(span));
              end else begin
                ans_d = ans_q + CntW'(popcount(span &
                        ((word_t'(1) << lsb_index(used)) - word_t'(1))));
                run_d = 1'b0;
              end
            end
          end else if (cmd_q == CmdTest) begin
            if (pw == start_q[BlkW-1:OffW]) begin
              ans_d = CntW'(old_word[start_q[OffW-1:0]]);
            end
          end
        end
      end
      SDone: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    fin_answer = ans_q;
    fin_status = StatOk;
    if (range_bad) begin
      fin_answer = '0;
      fin_status = StatRange;
    end else if ((cmd_q == CmdFindFree) && !found_q) begin
      fin_answer = '0;
      fin_status = StatNoFree;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      step_q      <= '0;
      blocks_q    <= CntW'(MaxBlocks);
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      run_q       <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      found_q  <= found_d;
      run_q    <= run_d;
      if (cfg_we_i) begin
        blocks_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        vld_q[pw] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_q <= vld_q[rd_addr];
      end
      if ((state_q == SDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ans_q  <= ans_d;
    free_q <= free_d;
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      start_q <= start_block_i;
      len_q   <= run_length_i;
    end
    if ((state_q == SDone) && out_free) begin
      answer_q     <= fin_answer;
      free_total_q <= free_q;
      status_q     <= fin_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign answer_o     = answer_q;
  assign free_total_o = free_total_q;
  assign status_o     = status_q;

  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && rd_en) |-> (pw != rd_addr))
    else $error("map word written while read in the same cycle");

  a_scan_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == SScan) && (step_q == '0))
    else $error("sweep did not start after input transfer");

  a_no_write_on_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> is_run && !range_bad)
    else $error("map written by a query or rejected run");

  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (free_total_o <= n_act))
    else $error("free total above blocks in use");

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == StatRange) || (status_o == StatNoFree)))
      |-> (answer_o == '0))
    else $error("nonzero answer with error status");

endmodule

`default_nettype wire
